// ===== rtl/swa_pkg.sv =====
// Shared types, constants and the sigmoid segment tables for the SwiGLU block.
`default_nettype none
package swa_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int FRAC_BITS     = 12;
	localparam int SEGMENT_COUNT = 32;

	localparam int GRID_POINTS = 256;
	localparam int HALF_GRID   = GRID_POINTS / 2;
	localparam int GRID_SHIFT  = FRAC_BITS - 4;
	localparam int SEG_RATIO   = GRID_POINTS / SEGMENT_COUNT;
	localparam int SEG_SHIFT   = GRID_SHIFT + $clog2(SEG_RATIO);
	localparam int SEG_IDX_W   = $clog2(SEGMENT_COUNT);
	localparam int SIG_W       = 17;
	localparam int SIG_FRAC    = 16;
	localparam int EXT_W       = ((DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4) + 1;
	localparam int XS_W        = DATA_WIDTH + SIG_W + 1;
	localparam int SILU_W      = DATA_WIDTH + 1;
	localparam int PR_W        = 2 * DATA_WIDTH + 1;

	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << SIG_FRAC;

	localparam logic signed [EXT_W-1:0] RANGE_HI = EXT_W'(1) << (FRAC_BITS + 3);
	localparam logic signed [EXT_W-1:0] RANGE_LO = -RANGE_HI;

	localparam logic signed [XS_W-1:0] XS_HALF = XS_W'(1) << (SIG_FRAC - 1);
	localparam logic signed [PR_W-1:0] PR_HALF = PR_W'(1) << (FRAC_BITS - 1);

	localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [PR_W-1:0] RES_MAX = PR_W'(OUT_MAX);
	localparam logic signed [PR_W-1:0] RES_MIN = PR_W'(OUT_MIN);

	typedef logic [SIG_W-1:0] sig_grid_t [GRID_POINTS+1];
	typedef logic [SIG_W-1:0] seg_tab_t [SEGMENT_COUNT];

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] gate_value;
		logic signed [DATA_WIDTH-1:0] up_value;
	} swa_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] product;
		logic                         overflow;
	} swa_out_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] gate_value;
		logic signed [DATA_WIDTH-1:0] up_value;
		logic        [SIG_W-1:0]      sig;
	} swa_sig_t;

	// Restoring long division for building the constant tables.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid samples in Q16 on the grid k/16 - 8, from e^(-m/16) in Q32.
	function automatic sig_grid_t build_sig_grid();
		logic [63:0] e [HALF_GRID+1];
		logic [63:0] ev;
		logic [63:0] den;
		logic [63:0] num;
		int          m;
		sig_grid_t   g;
		e[0] = 64'd1 << 32;
		for (int k = 1; k <= HALF_GRID; k++) begin
			e[k] = (e[k-1] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		for (int k = 0; k <= GRID_POINTS; k++) begin
			m   = k - HALF_GRID;
			ev  = e[(m >= 0) ? m : -m];
			den = (64'd1 << 32) + ev;
			num = (m >= 0) ? (64'd1 << 48) : (ev << 16);
			g[k] = SIG_W'(udiv64(num + (den >> 1), den));
		end
		return g;
	endfunction

	function automatic seg_tab_t build_seg_y0(sig_grid_t g);
		seg_tab_t t;
		for (int s = 0; s < SEGMENT_COUNT; s++) begin
			t[s] = g[s * SEG_RATIO];
		end
		return t;
	endfunction

	function automatic seg_tab_t build_seg_dy(sig_grid_t g);
		seg_tab_t t;
		for (int s = 0; s < SEGMENT_COUNT; s++) begin
			t[s] = g[(s + 1) * SEG_RATIO] - g[s * SEG_RATIO];
		end
		return t;
	endfunction

	localparam sig_grid_t SIG_GRID = build_sig_grid();
	localparam seg_tab_t  SEG_Y0   = build_seg_y0(SIG_GRID);
	localparam seg_tab_t  SEG_DY   = build_seg_dy(SIG_GRID);

endpackage
`default_nettype wire

// ===== rtl/swa_sigmoid.sv =====
// Four-stage piecewise-linear sigmoid of the gate element, up element carried along.
`default_nettype none
module swa_sigmoid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire swa_pkg::swa_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output swa_pkg::swa_sig_t      out_data
);

	logic signed [swa_pkg::EXT_W-1:0] x_ext;
	logic        [swa_pkg::EXT_W-1:0] x_pos;
	logic take_s1, take_s2, take_s3, take_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [swa_pkg::DATA_WIDTH-1:0] x_s1, x_s2, x_s3;
	logic signed [swa_pkg::DATA_WIDTH-1:0] up_s1, up_s2, up_s3;
	logic [swa_pkg::SEG_IDX_W-1:0] seg_s1;
	logic [swa_pkg::SEG_SHIFT-1:0] off_s1, off_s2;
	logic below_s1, below_s2, below_s3;
	logic above_s1, above_s2, above_s3;
	logic [swa_pkg::SIG_W-1:0] y0_s2, y0_s3, dy_s2;
	logic [swa_pkg::SIG_W+swa_pkg::SEG_SHIFT-1:0] interp_s3;
	swa_pkg::swa_sig_t beat_s4;

	assign x_ext = swa_pkg::EXT_W'(in_data.gate_value);
	assign x_pos = x_ext - swa_pkg::RANGE_LO;

	assign take_s4  = !vld_s4 || out_ready;
	assign take_s3  = !vld_s3 || take_s4;
	assign take_s2  = !vld_s2 || take_s3;
	assign take_s1  = !vld_s1 || take_s2;
	assign in_ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (take_s1) vld_s1 <= in_valid;
			if (take_s2) vld_s2 <= vld_s1;
			if (take_s3) vld_s3 <= vld_s2;
			if (take_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			x_s1     <= in_data.gate_value;
			up_s1    <= in_data.up_value;
			seg_s1   <= x_pos[swa_pkg::SEG_SHIFT +: swa_pkg::SEG_IDX_W];
			off_s1   <= x_pos[swa_pkg::SEG_SHIFT-1:0];
			below_s1 <= x_ext < swa_pkg::RANGE_LO;
			above_s1 <= x_ext >= swa_pkg::RANGE_HI;
		end
		if (take_s2) begin
			x_s2     <= x_s1;
			up_s2    <= up_s1;
			off_s2   <= off_s1;
			below_s2 <= below_s1;
			above_s2 <= above_s1;
			y0_s2    <= swa_pkg::SEG_Y0[seg_s1];
			dy_s2    <= swa_pkg::SEG_DY[seg_s1];
		end
		if (take_s3) begin
			x_s3      <= x_s2;
			up_s3     <= up_s2;
			below_s3  <= below_s2;
			above_s3  <= above_s2;
			y0_s3     <= y0_s2;
			interp_s3 <= {{swa_pkg::SEG_SHIFT{1'b0}}, dy_s2}
				* {{swa_pkg::SIG_W{1'b0}}, off_s2};
		end
		if (take_s4) begin
			beat_s4.gate_value <= x_s3;
			beat_s4.up_value   <= up_s3;
			if (below_s3) begin
				beat_s4.sig <= '0;
			end else if (above_s3) begin
				beat_s4.sig <= swa_pkg::SIG_ONE;
			end else begin
				beat_s4.sig <= y0_s3 + interp_s3[swa_pkg::SEG_SHIFT +: swa_pkg::SIG_W];
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = beat_s4;

endmodule
`default_nettype wire

// ===== rtl/swa_gate_mul.sv =====
// Four-stage gated product: x*sigmoid, round, times up, round and saturate.
`default_nettype none
module swa_gate_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire swa_pkg::swa_sig_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output swa_pkg::swa_out_t      out_data
);

	logic take_s5, take_s6, take_s7, take_s8;
	logic vld_s5, vld_s6, vld_s7, vld_s8;

	logic signed [swa_pkg::XS_W-1:0]       xs_s5;
	logic signed [swa_pkg::XS_W-1:0]       xs_rnd;
	logic signed [swa_pkg::DATA_WIDTH-1:0] up_s5, up_s6;
	logic signed [swa_pkg::SILU_W-1:0]     silu_s6;
	logic signed [swa_pkg::PR_W-1:0]       prod_s7;
	logic signed [swa_pkg::PR_W-1:0]       res_rnd;
	swa_pkg::swa_out_t                     res_s8;

	assign xs_rnd  = xs_s5 + swa_pkg::XS_HALF;
	assign res_rnd = (prod_s7 + swa_pkg::PR_HALF) >>> swa_pkg::FRAC_BITS;

	assign take_s8  = !vld_s8 || out_ready;
	assign take_s7  = !vld_s7 || take_s8;
	assign take_s6  = !vld_s6 || take_s7;
	assign take_s5  = !vld_s5 || take_s6;
	assign in_ready = take_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (take_s5) vld_s5 <= in_valid;
			if (take_s6) vld_s6 <= vld_s5;
			if (take_s7) vld_s7 <= vld_s6;
			if (take_s8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s5) begin
			xs_s5 <= swa_pkg::XS_W'(in_data.gate_value)
				* swa_pkg::XS_W'($signed({1'b0, in_data.sig}));
			up_s5 <= in_data.up_value;
		end
		if (take_s6) begin
			silu_s6 <= xs_rnd[swa_pkg::SIG_FRAC +: swa_pkg::SILU_W];
			up_s6   <= up_s5;
		end
		if (take_s7) begin
			prod_s7 <= swa_pkg::PR_W'(silu_s6) * swa_pkg::PR_W'(up_s6);
		end
		if (take_s8) begin
			if (res_rnd > swa_pkg::RES_MAX) begin
				res_s8.product  <= swa_pkg::OUT_MAX;
				res_s8.overflow <= 1'b1;
			end else if (res_rnd < swa_pkg::RES_MIN) begin
				res_s8.product  <= swa_pkg::OUT_MIN;
				res_s8.overflow <= 1'b1;
			end else begin
				res_s8.product  <= res_rnd[swa_pkg::DATA_WIDTH-1:0];
				res_s8.overflow <= 1'b0;
			end
		end
	end

	assign out_valid = vld_s8;
	assign out_data  = res_s8;

endmodule
`default_nettype wire

// ===== rtl/swiglu_activation_top.sv =====
// Top level of the SwiGLU activation block: sigmoid pipeline feeding the gated product.
//
//   channel | direction | handshake          | beat
//   in      | sink      | in_valid/in_ready   | swa_in_t  (gate_value, up_value)
//   out     | source    | out_valid/out_ready | swa_out_t (product, overflow)
//
// One beat per cycle sustained while out is not stalled.
// The path runs through eight register stages: four for the sigmoid segment
// lookup and interpolation, four for the two multiplies with their rounding.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall on out freezes the unbroken run of full stages behind it; other stages keep moving into empty ones.
`default_nettype none
module swiglu_activation_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire swa_pkg::swa_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output swa_pkg::swa_out_t     out_data
);

	logic              sig_valid;
	logic              sig_ready;
	swa_pkg::swa_sig_t sig_data;

	swa_sigmoid u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (sig_valid),
		.out_ready (sig_ready),
		.out_data  (sig_data)
	);

	swa_gate_mul u_gate_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sig_valid),
		.in_ready  (sig_ready),
		.in_data   (sig_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== rtl/swa_checker.sv =====
// Port-level checks for the SwiGLU activation block, bound to its top level.
`default_nettype none
module swa_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire swa_pkg::swa_out_t out_data
);

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.overflow) |->
		(out_data.product == swa_pkg::OUT_MAX || out_data.product == swa_pkg::OUT_MIN))
		else $error("overflow set on unsaturated product");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled output beat changed");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind swiglu_activation_top swa_checker u_swa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
